// ===== rtl/core/arc_page_replacer_top_assert.svh =====
// Assertion macros for the ARC page replacer top level.
// Used by arc_page_replacer_top.sv; no other dependencies.
`ifndef ARC_PAGE_REPLACER_TOP_ASSERT_SVH
`define ARC_PAGE_REPLACER_TOP_ASSERT_SVH
// invariant checked on every edge out of reset
`define ACP_ASSERT(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);
// implication whose consequent is checked in the next cycle
`define ACP_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/core/acp_pkg.sv =====
// Shared types and constants for the ARC page replacer.
// No dependencies; used by every other file of the block but the assertion header.
package acp_pkg;
	localparam int FRAME_SLOTS = 16;
	localparam int PAGE_W      = 31;
	localparam int FRAME_W     = $clog2(FRAME_SLOTS);
	localparam int RG_DEPTH    = FRAME_SLOTS;
	localparam int FG_DEPTH    = 2 * FRAME_SLOTS;
	localparam int CNT_W       = $clog2(FRAME_SLOTS + 1);
	localparam int FG_CNT_W    = $clog2(FG_DEPTH + 1);
	localparam int IDX_W       = $clog2(FG_DEPTH);
	localparam int CAP_W       = 5;
	localparam int DQ_W        = FG_CNT_W;

	typedef enum logic [1:0] {
		CMD_ACCESS,
		CMD_SET_EVICT,
		CMD_REMOVE,
		CMD_EVICT
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_RANGE,
		ST_OTHER_PAGE,
		ST_PINNED
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_TAKE,
		S_TAKE_RM,
		S_GR,
		S_FG,
		S_DIV,
		S_GHIT,
		S_MKF,
		S_MISS,
		S_EV,
		S_EV_RM,
		S_DONE
	} state_t;

	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctl_t;
endpackage

// ===== rtl/core/acp_ifs.sv =====
// Command and result channel interfaces of the ARC page replacer.
// Depends on acp_pkg.
interface acp_req_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   command;
	logic [acp_pkg::FRAME_W-1:0]  frame_sel;
	logic [acp_pkg::PAGE_W-1:0]   page_id;
	logic                         make_evictable;

	modport source (output valid, command, frame_sel, page_id, make_evictable, input ready);
	modport sink (input valid, command, frame_sel, page_id, make_evictable, output ready);
endinterface

interface acp_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         victim_valid;
	logic [acp_pkg::FRAME_W-1:0]  victim_frame;
	logic [acp_pkg::CNT_W-1:0]    evictable_count;
	logic [1:0]                   status;

	modport source (output valid, victim_valid, victim_frame, evictable_count, status,
		input ready);
	modport sink (input valid, victim_valid, victim_frame, evictable_count, status,
		output ready);
endinterface

// ===== rtl/core/acp_order_cell.sv =====
// One cell of a live frame order list: holds a frame id, shifts from its
// newer neighbor or loads a pushed id. Depends on acp_pkg.
module acp_order_cell (
	input  logic                        clk,
	input  acp_pkg::cell_ctl_t          ctl,
	input  logic [acp_pkg::FRAME_W-1:0] nbr,
	input  logic [acp_pkg::FRAME_W-1:0] ld,
	output logic [acp_pkg::FRAME_W-1:0] val
);
	logic [acp_pkg::FRAME_W-1:0] val_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			val_q <= ld;
		end else if (ctl.shift) begin
			val_q <= nbr;
		end
	end

	assign val = val_q;
endmodule

// ===== rtl/core/acp_ghost_cell.sv =====
// One cell of a ghost page list: holds a page id, shifts or loads, and
// compares its page against the search key. Depends on acp_pkg.
module acp_ghost_cell (
	input  logic                       clk,
	input  acp_pkg::cell_ctl_t         ctl,
	input  logic [acp_pkg::PAGE_W-1:0] nbr,
	input  logic [acp_pkg::PAGE_W-1:0] ld,
	input  logic [acp_pkg::PAGE_W-1:0] key,
	output logic [acp_pkg::PAGE_W-1:0] val,
	output logic                       hit
);
	logic [acp_pkg::PAGE_W-1:0] val_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			val_q <= ld;
		end else if (ctl.shift) begin
			val_q <= nbr;
		end
	end

	assign val = val_q;
	assign hit = (val_q == key);
endmodule

// ===== rtl/core/arc_page_replacer_top.sv =====
// ARC page replacer: a set evictable goes from decode straight to the result; a hit, a remove
// or an evict walks an order list; an access miss scans the ghost lists (one ghost entry per
// cycle, up to 16 recent then 32 frequent ghosts; a ghost hit may add a divide).
// One command at a time: the next transfer is taken the cycle after the result is
// registered; a full result register stalls.
// Reset (arst_n low, async): all lists empty, no frame live, capacity 16.
`include "arc_page_replacer_top_assert.svh"
module arc_page_replacer_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [acp_pkg::CAP_W-1:0] cfg_wdata,
	acp_req_if.sink                   req,
	acp_rsp_if.source                 rsp
);
	localparam int NF  = acp_pkg::FRAME_SLOTS;
	localparam int FW  = acp_pkg::FRAME_W;
	localparam int PW  = acp_pkg::PAGE_W;
	localparam int CW  = acp_pkg::CNT_W;
	localparam int GCW = acp_pkg::FG_CNT_W;
	localparam int IW  = acp_pkg::IDX_W;
	localparam int RGD = acp_pkg::RG_DEPTH;
	localparam int FGD = acp_pkg::FG_DEPTH;
	localparam int DW  = acp_pkg::DQ_W;

	acp_pkg::state_t  state_q, state_d;
	acp_pkg::cmd_t    cmd_q;
	acp_pkg::status_t status_q;

	logic [acp_pkg::CAP_W-1:0] cap_q, cap_c;
	logic [NF-1:0]  live_q, freq_q, evict_q;
	logic [CW-1:0]  rc_q, fc_q, rgc_q, target_q, total_q;
	logic [GCW-1:0] fgc_q;
	logic [IW:0]    idx_q;
	logic           side_q, second_q, gfreq_q, vvalid_q;
	logic [FW-1:0]  fid_q, victim_q;
	logic [PW-1:0]  page_q;
	logic           mk_q;
	logic [PW-1:0]  frame_page_q [NF];

	logic [DW-1:0]  div_rem_q, div_quo_q;
	logic [CW-1:0]  div_den_q;
	logic [2:0]     div_cnt_q;
	logic [DW:0]    div_r;
	logic           div_ge;

	logic           out_valid_q, out_vv_q;
	logic [FW-1:0]  out_victim_q;
	logic [CW-1:0]  out_cnt_q;
	logic [1:0]     out_status_q;

	logic           ro_rm, ro_push, fo_rm, fo_push, rg_rm, rg_push, fg_rm, fg_push;
	logic [IW-1:0]  rm_idx;
	logic [FW-1:0]  pg_addr, cur_val;
	logic [PW-1:0]  pg_rd;
	logic [CW-1:0]  cur_cnt;
	logic           f_oor, rg_full, fg_full;
	logic [CW-1:0]  rg_tail;
	logic [GCW-1:0] fg_tail;
	logic [CW:0]    side_sum;
	logic [CW+1:0]  all_sum;
	logic [CW+1:0]  tgt_up;

	logic [FW-1:0]      ro_val [NF];
	logic [FW-1:0]      fo_val [NF];
	logic [PW-1:0]      rg_val [RGD];
	logic [PW-1:0]      fg_val [FGD];
	logic [RGD-1:0]     rg_hit;
	logic [FGD-1:0]     fg_hit;
	acp_pkg::cell_ctl_t ro_ctl [NF];
	acp_pkg::cell_ctl_t fo_ctl [NF];
	acp_pkg::cell_ctl_t rg_ctl [RGD];
	acp_pkg::cell_ctl_t fg_ctl [FGD];

	// capacity clamped to 1..FRAME_SLOTS
	always_comb begin
		if (cap_q == '0) begin
			cap_c = acp_pkg::CAP_W'(1);
		end else if ({1'b0, cap_q} > (acp_pkg::CAP_W + 1)'(NF)) begin
			cap_c = acp_pkg::CAP_W'(NF);
		end else begin
			cap_c = cap_q;
		end
	end

	assign f_oor    = {1'b0, fid_q} >= cap_c;
	assign pg_addr  = (state_q == acp_pkg::S_EV_RM) ? victim_q : fid_q;
	assign pg_rd    = frame_page_q[pg_addr];
	assign cur_cnt  = side_q ? fc_q : rc_q;
	assign cur_val  = side_q ? fo_val[idx_q[FW-1:0]] : ro_val[idx_q[FW-1:0]];
	assign rg_full  = (rgc_q == CW'(RGD));
	assign fg_full  = (fgc_q == GCW'(FGD));
	assign rg_tail  = rg_full ? CW'(RGD - 1) : rgc_q;
	assign fg_tail  = fg_full ? GCW'(FGD - 1) : fgc_q;
	assign side_sum = {1'b0, rc_q} + {1'b0, rgc_q};
	assign all_sum  = {1'b0, side_sum} + (CW + 2)'(fc_q) + (CW + 2)'(fgc_q);
	assign tgt_up   = (CW + 2)'(target_q) + (CW + 2)'(div_quo_q);
	assign div_r    = {div_rem_q, div_quo_q[DW-1]};
	assign div_ge   = div_r >= (DW + 1)'(div_den_q);

	// cell chains
	for (genvar j = 0; j < NF; j++) begin : g_order
		assign ro_ctl[j].shift = ro_rm && (IW'(j) >= rm_idx);
		assign ro_ctl[j].load  = ro_push && (CW'(j) == rc_q);
		assign fo_ctl[j].shift = fo_rm && (IW'(j) >= rm_idx);
		assign fo_ctl[j].load  = fo_push && (CW'(j) == fc_q);
		if (j == NF - 1) begin : g_last
			acp_order_cell u_ro (.clk, .ctl(ro_ctl[j]), .nbr('0), .ld(fid_q),
				.val(ro_val[j]));
			acp_order_cell u_fo (.clk, .ctl(fo_ctl[j]), .nbr('0), .ld(fid_q),
				.val(fo_val[j]));
		end else begin : g_mid
			acp_order_cell u_ro (.clk, .ctl(ro_ctl[j]), .nbr(ro_val[j+1]), .ld(fid_q),
				.val(ro_val[j]));
			acp_order_cell u_fo (.clk, .ctl(fo_ctl[j]), .nbr(fo_val[j+1]), .ld(fid_q),
				.val(fo_val[j]));
		end
	end

	for (genvar j = 0; j < RGD; j++) begin : g_rg
		assign rg_ctl[j].shift = (rg_rm && (IW'(j) >= rm_idx)) || (rg_push && rg_full);
		assign rg_ctl[j].load  = rg_push && (CW'(j) == rg_tail);
		if (j == RGD - 1) begin : g_last
			acp_ghost_cell u_c (.clk, .ctl(rg_ctl[j]), .nbr('0), .ld(pg_rd), .key(page_q),
				.val(rg_val[j]), .hit(rg_hit[j]));
		end else begin : g_mid
			acp_ghost_cell u_c (.clk, .ctl(rg_ctl[j]), .nbr(rg_val[j+1]), .ld(pg_rd),
				.key(page_q), .val(rg_val[j]), .hit(rg_hit[j]));
		end
	end

	for (genvar j = 0; j < FGD; j++) begin : g_fg
		assign fg_ctl[j].shift = (fg_rm && (IW'(j) >= rm_idx)) || (fg_push && fg_full);
		assign fg_ctl[j].load  = fg_push && (GCW'(j) == fg_tail);
		if (j == FGD - 1) begin : g_last
			acp_ghost_cell u_c (.clk, .ctl(fg_ctl[j]), .nbr('0), .ld(pg_rd), .key(page_q),
				.val(fg_val[j]), .hit(fg_hit[j]));
		end else begin : g_mid
			acp_ghost_cell u_c (.clk, .ctl(fg_ctl[j]), .nbr(fg_val[j+1]), .ld(pg_rd),
				.key(page_q), .val(fg_val[j]), .hit(fg_hit[j]));
		end
	end

	// sequencer: next state and list strobes
	always_comb begin
		state_d = state_q;
		ro_rm   = 1'b0;
		ro_push = 1'b0;
		fo_rm   = 1'b0;
		fo_push = 1'b0;
		rg_rm   = 1'b0;
		rg_push = 1'b0;
		fg_rm   = 1'b0;
		fg_push = 1'b0;
		rm_idx  = idx_q[IW-1:0];
		case (state_q)
			acp_pkg::S_IDLE: begin
				if (req.valid) begin
					state_d = acp_pkg::S_DECODE;
				end
			end
			acp_pkg::S_DECODE: begin
				case (cmd_q)
					acp_pkg::CMD_ACCESS: begin
						if (f_oor) begin
							state_d = acp_pkg::S_DONE;
						end else if (live_q[fid_q]) begin
							state_d = (pg_rd != page_q) ? acp_pkg::S_DONE : acp_pkg::S_TAKE;
						end else if (rgc_q != '0) begin
							state_d = acp_pkg::S_GR;
						end else if (fgc_q != '0) begin
							state_d = acp_pkg::S_FG;
						end else begin
							state_d = acp_pkg::S_MISS;
						end
					end
					acp_pkg::CMD_REMOVE: begin
						state_d = (live_q[fid_q] && evict_q[fid_q]) ? acp_pkg::S_TAKE
							: acp_pkg::S_DONE;
					end
					acp_pkg::CMD_EVICT: begin
						state_d = (total_q != '0) ? acp_pkg::S_EV : acp_pkg::S_DONE;
					end
					default: begin
						state_d = acp_pkg::S_DONE;
					end
				endcase
			end
			acp_pkg::S_TAKE: begin
				if (idx_q >= (IW + 1)'(cur_cnt)) begin
					state_d = acp_pkg::S_DONE;
				end else if (cur_val == fid_q) begin
					state_d = acp_pkg::S_TAKE_RM;
				end
			end
			acp_pkg::S_TAKE_RM: begin
				ro_rm   = !side_q;
				fo_rm   = side_q;
				state_d = (cmd_q == acp_pkg::CMD_ACCESS) ? acp_pkg::S_MKF : acp_pkg::S_DONE;
			end
			acp_pkg::S_GR: begin
				if (rg_hit[idx_q[FW-1:0]]) begin
					state_d = (rgc_q < fgc_q[CW-1:0] || fgc_q > GCW'(rgc_q)) ? acp_pkg::S_DIV
						: acp_pkg::S_GHIT;
				end else if (idx_q == '0) begin
					state_d = (fgc_q != '0) ? acp_pkg::S_FG : acp_pkg::S_MISS;
				end
			end
			acp_pkg::S_FG: begin
				if (fg_hit[idx_q[IW-1:0]]) begin
					state_d = (fgc_q < GCW'(rgc_q)) ? acp_pkg::S_DIV : acp_pkg::S_GHIT;
				end else if (idx_q == '0) begin
					state_d = acp_pkg::S_MISS;
				end
			end
			acp_pkg::S_DIV: begin
				if (div_cnt_q == 3'd1) begin
					state_d = acp_pkg::S_GHIT;
				end
			end
			acp_pkg::S_GHIT: begin
				rg_rm   = !gfreq_q;
				fg_rm   = gfreq_q;
				state_d = acp_pkg::S_MKF;
			end
			acp_pkg::S_MKF: begin
				fo_push = 1'b1;
				state_d = acp_pkg::S_DONE;
			end
			acp_pkg::S_MISS: begin
				rm_idx = '0;
				if (side_sum == (CW + 1)'(cap_c)) begin
					rg_rm = (rgc_q != '0);
				end else if (side_sum < (CW + 1)'(cap_c) &&
						all_sum == (CW + 2)'({cap_c, 1'b0})) begin
					fg_rm = (fgc_q != '0);
				end
				ro_push = 1'b1;
				state_d = acp_pkg::S_DONE;
			end
			acp_pkg::S_EV: begin
				if (idx_q >= (IW + 1)'(cur_cnt)) begin
					if (second_q) begin
						state_d = acp_pkg::S_DONE;
					end
				end else if (evict_q[cur_val]) begin
					state_d = acp_pkg::S_EV_RM;
				end
			end
			acp_pkg::S_EV_RM: begin
				ro_rm   = !side_q;
				fo_rm   = side_q;
				rg_push = !side_q;
				fg_push = side_q;
				state_d = acp_pkg::S_DONE;
			end
			acp_pkg::S_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					state_d = acp_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = acp_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= acp_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control and list state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= acp_pkg::CAP_W'(NF);
			live_q      <= '0;
			freq_q      <= '0;
			evict_q     <= '0;
			rc_q        <= '0;
			fc_q        <= '0;
			rgc_q       <= '0;
			fgc_q       <= '0;
			target_q    <= '0;
			total_q     <= '0;
			idx_q       <= '0;
			side_q      <= 1'b0;
			second_q    <= 1'b0;
			gfreq_q     <= 1'b0;
			vvalid_q    <= 1'b0;
			victim_q    <= '0;
			status_q    <= acp_pkg::ST_OK;
			cmd_q       <= acp_pkg::CMD_ACCESS;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (ro_rm) rc_q <= rc_q - CW'(1);
			if (ro_push) rc_q <= rc_q + CW'(1);
			if (fo_rm) fc_q <= fc_q - CW'(1);
			if (fo_push) fc_q <= fc_q + CW'(1);
			if (rg_rm) rgc_q <= rgc_q - CW'(1);
			if (rg_push && !rg_full) rgc_q <= rgc_q + CW'(1);
			if (fg_rm) fgc_q <= fgc_q - GCW'(1);
			if (fg_push && !fg_full) fgc_q <= fgc_q + GCW'(1);

			if (state_q == acp_pkg::S_DONE && (!out_valid_q || rsp.ready)) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				acp_pkg::S_IDLE: begin
					if (req.valid) begin
						cmd_q    <= acp_pkg::cmd_t'(req.command);
						status_q <= acp_pkg::ST_OK;
						vvalid_q <= 1'b0;
						victim_q <= '0;
						idx_q    <= '0;
						second_q <= 1'b0;
					end
				end
				acp_pkg::S_DECODE: begin
					case (cmd_q)
						acp_pkg::CMD_ACCESS: begin
							if (f_oor) begin
								status_q <= acp_pkg::ST_RANGE;
							end else if (live_q[fid_q]) begin
								if (pg_rd != page_q) status_q <= acp_pkg::ST_OTHER_PAGE;
								side_q <= freq_q[fid_q];
							end else if (rgc_q != '0) begin
								idx_q <= (IW + 1)'(rgc_q - CW'(1));
							end else begin
								idx_q <= (IW + 1)'(fgc_q - GCW'(1));
							end
						end
						acp_pkg::CMD_SET_EVICT: begin
							if (f_oor) begin
								status_q <= acp_pkg::ST_RANGE;
							end else if (live_q[fid_q] && (evict_q[fid_q] != mk_q)) begin
								evict_q[fid_q] <= mk_q;
								if (mk_q) begin
									total_q <= total_q + CW'(1);
								end else if (total_q != '0) begin
									total_q <= total_q - CW'(1);
								end
							end
						end
						acp_pkg::CMD_REMOVE: begin
							if (live_q[fid_q] && !evict_q[fid_q]) status_q <= acp_pkg::ST_PINNED;
							side_q <= freq_q[fid_q];
						end
						default: begin
							side_q <= (rc_q < target_q);
						end
					endcase
				end
				acp_pkg::S_TAKE: begin
					if (state_d == acp_pkg::S_TAKE) idx_q <= idx_q + (IW + 1)'(1);
				end
				acp_pkg::S_TAKE_RM: begin
					if (cmd_q == acp_pkg::CMD_REMOVE) begin
						live_q[fid_q]  <= 1'b0;
						freq_q[fid_q]  <= 1'b0;
						evict_q[fid_q] <= 1'b0;
						if (total_q != '0) total_q <= total_q - CW'(1);
					end
				end
				acp_pkg::S_GR: begin
					if (rg_hit[idx_q[FW-1:0]]) begin
						gfreq_q <= 1'b0;
					end else if (idx_q == '0) begin
						idx_q <= (IW + 1)'(fgc_q - GCW'(1));
					end else begin
						idx_q <= idx_q - (IW + 1)'(1);
					end
					div_cnt_q <= 3'(DW);
				end
				acp_pkg::S_FG: begin
					if (fg_hit[idx_q[IW-1:0]]) begin
						gfreq_q <= 1'b1;
					end else if (idx_q != '0) begin
						idx_q <= idx_q - (IW + 1)'(1);
					end
					div_cnt_q <= 3'(DW);
				end
				acp_pkg::S_DIV: begin
					div_cnt_q <= div_cnt_q - 3'd1;
				end
				acp_pkg::S_GHIT: begin
					if (!gfreq_q) begin
						target_q <= (tgt_up > (CW + 2)'(cap_c)) ? CW'(cap_c) : tgt_up[CW-1:0];
					end else begin
						target_q <= (div_quo_q > DW'(target_q)) ? '0
							: target_q - div_quo_q[CW-1:0];
					end
				end
				acp_pkg::S_MKF: begin
					live_q[fid_q] <= 1'b1;
					freq_q[fid_q] <= 1'b1;
				end
				acp_pkg::S_MISS: begin
					live_q[fid_q] <= 1'b1;
					freq_q[fid_q] <= 1'b0;
				end
				acp_pkg::S_EV: begin
					if (idx_q >= (IW + 1)'(cur_cnt)) begin
						if (!second_q) begin
							side_q   <= !side_q;
							second_q <= 1'b1;
							idx_q    <= '0;
						end
					end else if (evict_q[cur_val]) begin
						victim_q <= cur_val;
					end else begin
						idx_q <= idx_q + (IW + 1)'(1);
					end
				end
				acp_pkg::S_EV_RM: begin
					live_q[victim_q]  <= 1'b0;
					freq_q[victim_q]  <= 1'b0;
					evict_q[victim_q] <= 1'b0;
					if (total_q != '0) total_q <= total_q - CW'(1);
					vvalid_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == acp_pkg::S_IDLE && req.valid) begin
			fid_q  <= req.frame_sel;
			page_q <= req.page_id;
			mk_q   <= req.make_evictable;
		end
		if (state_q == acp_pkg::S_MKF || state_q == acp_pkg::S_MISS) begin
			frame_page_q[fid_q] <= page_q;
		end
		if (state_q == acp_pkg::S_GR && rg_hit[idx_q[FW-1:0]]) begin
			div_rem_q <= '0;
			div_den_q <= rgc_q;
			div_quo_q <= (fgc_q > GCW'(rgc_q)) ? DW'(fgc_q) : DW'(1);
		end else if (state_q == acp_pkg::S_FG && fg_hit[idx_q[IW-1:0]]) begin
			div_rem_q <= '0;
			div_den_q <= fgc_q[CW-1:0];
			div_quo_q <= (fgc_q < GCW'(rgc_q)) ? DW'(rgc_q) : DW'(1);
		end else if (state_q == acp_pkg::S_DIV) begin
			div_rem_q <= div_ge ? DW'(div_r - (DW + 1)'(div_den_q)) : div_r[DW-1:0];
			div_quo_q <= {div_quo_q[DW-2:0], div_ge};
		end
		if (state_q == acp_pkg::S_DONE && (!out_valid_q || rsp.ready)) begin
			out_vv_q     <= vvalid_q;
			out_victim_q <= victim_q;
			out_cnt_q    <= total_q;
			out_status_q <= status_q;
		end
	end

	assign req.ready           = (state_q == acp_pkg::S_IDLE);
	assign rsp.valid           = out_valid_q;
	assign rsp.victim_valid    = out_vv_q;
	assign rsp.victim_frame    = out_victim_q;
	assign rsp.evictable_count = out_cnt_q;
	assign rsp.status          = out_status_q;

	`ACP_ASSERT(a_total_matches, clk, arst_n, $countones(evict_q) == 32'(total_q), "evictable count drift")
	`ACP_ASSERT(a_evict_live, clk, arst_n, (evict_q & ~live_q) == '0, "evictable frame not live")
	`ACP_ASSERT(a_live_fit, clk, arst_n, ({1'b0, rc_q} + {1'b0, fc_q}) <= (CW + 1)'(NF), "live lists overfull")
	`ACP_ASSERT_NEXT(a_evict_dec, clk, arst_n, state_q == acp_pkg::S_EV_RM, total_q == $past(total_q) - CW'(1), "evict did not drop count")
endmodule

// ===== bench/acp_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the ARC page replacer: watches both channels, predicts each result.
// Depends on acp_pkg and the acp_req_if / acp_rsp_if interfaces.
module acp_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [acp_pkg::CAP_W-1:0] cfg_wdata,
	acp_req_if                        req,
	acp_rsp_if                        rsp,
	output int                        errors,
	output int                        outstanding
);
	typedef struct {
		logic             victim_valid;
		logic [3:0]       victim_frame;
		logic [4:0]       evictable_count;
		acp_pkg::status_t status;
	} result_t;

	result_t results_due[$];

	// side 0 recent, side 1 frequent
	logic [4:0]                 cap_reg;
	logic [3:0]                 order[2][acp_pkg::FRAME_SLOTS];
	int                         order_n[2];
	logic [acp_pkg::PAGE_W-1:0] ghost[2][acp_pkg::FG_DEPTH];
	int                         ghost_n[2];
	logic [acp_pkg::PAGE_W-1:0] page_of[acp_pkg::FRAME_SLOTS];
	bit                         live[acp_pkg::FRAME_SLOTS];
	bit                         on_freq[acp_pkg::FRAME_SLOTS];
	bit                         unpinned[acp_pkg::FRAME_SLOTS];
	int                         target;
	int                         unpinned_total;

	assign outstanding = results_due.size();

	function automatic int capacity();
		if (cap_reg < 1) return 1;
		if (cap_reg > acp_pkg::FRAME_SLOTS) return acp_pkg::FRAME_SLOTS;
		return cap_reg;
	endfunction

	function automatic void order_take(int s, int f);
		for (int i = 0; i < order_n[s]; i++) begin
			if (order[s][i] == f) begin
				for (int j = i; j < order_n[s] - 1; j++) order[s][j] = order[s][j + 1];
				order_n[s]--;
				return;
			end
		end
	endfunction

	function automatic void ghost_drop(int s, int idx);
		if (idx >= ghost_n[s]) return;
		for (int j = idx; j < ghost_n[s] - 1; j++) ghost[s][j] = ghost[s][j + 1];
		ghost_n[s]--;
	endfunction

	function automatic void ghost_push(int s, logic [acp_pkg::PAGE_W-1:0] p);
		if (ghost_n[s] >= (s ? acp_pkg::FG_DEPTH : acp_pkg::RG_DEPTH)) ghost_drop(s, 0);
		ghost[s][ghost_n[s]] = p;
		ghost_n[s]++;
	endfunction

	function automatic int ghost_find(int s, logic [acp_pkg::PAGE_W-1:0] p);
		for (int i = ghost_n[s] - 1; i >= 0; i--)
			if (ghost[s][i] == p) return i;
		return -1;
	endfunction

	function automatic void make_live(int f, logic [acp_pkg::PAGE_W-1:0] p, int s);
		order[s][order_n[s]] = 4'(f);
		order_n[s]++;
		page_of[f] = p;
		live[f] = 1;
		on_freq[f] = (s == 1);
		unpinned[f] = 0;
	endfunction

	function automatic int take_victim(int s);
		int f;
		for (int i = 0; i < order_n[s]; i++) begin
			f = order[s][i];
			if (unpinned[f]) begin
				for (int j = i; j < order_n[s] - 1; j++) order[s][j] = order[s][j + 1];
				order_n[s]--;
				ghost_push(s, page_of[f]);
				live[f] = 0;
				on_freq[f] = 0;
				unpinned[f] = 0;
				if (unpinned_total > 0) unpinned_total--;
				return f;
			end
		end
		return -1;
	endfunction

	function automatic acp_pkg::status_t access(int f, logic [acp_pkg::PAGE_W-1:0] p);
		int c, gi, d, side, total;
		c = capacity();
		if (f >= c) return acp_pkg::ST_RANGE;
		if (live[f]) begin
			if (page_of[f] != p) return acp_pkg::ST_OTHER_PAGE;
			order_take(on_freq[f], f);
			order[1][order_n[1]] = 4'(f);
			order_n[1]++;
			on_freq[f] = 1;
			return acp_pkg::ST_OK;
		end
		gi = ghost_find(0, p);
		if (gi >= 0) begin
			d = 1;
			if (ghost_n[0] < ghost_n[1]) d = ghost_n[1] / ghost_n[0];
			target = (target + d > c) ? c : target + d;
			ghost_drop(0, gi);
			make_live(f, p, 1);
			return acp_pkg::ST_OK;
		end
		gi = ghost_find(1, p);
		if (gi >= 0) begin
			d = 1;
			if (ghost_n[1] < ghost_n[0]) d = ghost_n[0] / ghost_n[1];
			target = (d > target) ? 0 : target - d;
			ghost_drop(1, gi);
			make_live(f, p, 1);
			return acp_pkg::ST_OK;
		end
		side = order_n[0] + ghost_n[0];
		total = side + order_n[1] + ghost_n[1];
		if (side == c) begin
			if (ghost_n[0] > 0) ghost_drop(0, 0);
		end else if (side < c && total == 2 * c) begin
			if (ghost_n[1] > 0) ghost_drop(1, 0);
		end
		make_live(f, p, 0);
		return acp_pkg::ST_OK;
	endfunction

	function automatic result_t replace_step(acp_pkg::cmd_t cmd, int f,
			logic [acp_pkg::PAGE_W-1:0] p, bit mk);
		result_t r;
		int v, pref;
		r.victim_valid = 0;
		r.victim_frame = 0;
		r.status = acp_pkg::ST_OK;
		case (cmd)
			acp_pkg::CMD_ACCESS: r.status = access(f, p);
			acp_pkg::CMD_SET_EVICT: begin
				if (f >= capacity()) r.status = acp_pkg::ST_RANGE;
				else if (live[f] && unpinned[f] != mk) begin
					unpinned[f] = mk;
					if (mk) unpinned_total++;
					else if (unpinned_total > 0) unpinned_total--;
				end
			end
			acp_pkg::CMD_REMOVE: begin
				if (live[f]) begin
					if (!unpinned[f]) r.status = acp_pkg::ST_PINNED;
					else begin
						order_take(on_freq[f], f);
						live[f] = 0;
						on_freq[f] = 0;
						unpinned[f] = 0;
						if (unpinned_total > 0) unpinned_total--;
					end
				end
			end
			default: begin
				if (unpinned_total > 0) begin
					pref = (order_n[0] < target) ? 1 : 0;
					v = take_victim(pref);
					if (v < 0) v = take_victim(1 - pref);
					if (v >= 0) begin
						r.victim_valid = 1;
						r.victim_frame = 4'(v);
					end
				end
			end
		endcase
		r.evictable_count = 5'(unpinned_total);
		return r;
	endfunction

	task automatic report(string field, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			cap_reg = 16;
			order_n = '{0, 0};
			ghost_n = '{0, 0};
			live = '{default: 0};
			on_freq = '{default: 0};
			unpinned = '{default: 0};
			target = 0;
			unpinned_total = 0;
			errors = 0;
			results_due.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (results_due.size() == 0) report("unexpected transfer", 1, 0);
				else begin
					want = results_due.pop_front();
					if (rsp.victim_valid !== want.victim_valid)
						report("victim_valid", rsp.victim_valid, want.victim_valid);
					if (rsp.victim_frame !== want.victim_frame)
						report("victim_frame", rsp.victim_frame, want.victim_frame);
					if (rsp.evictable_count !== want.evictable_count)
						report("evictable_count", rsp.evictable_count, want.evictable_count);
					if (rsp.status !== want.status) report("status", rsp.status, want.status);
				end
			end
			if (req.valid && req.ready)
				results_due.push_back(replace_step(acp_pkg::cmd_t'(req.command), req.frame_sel,
					req.page_id, req.make_evictable));
			if (cfg_we) cap_reg = cfg_wdata;
		end
	end
endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Top of the ARC page replacer bench: clock, reset, stimulus, config phases, verdict.
// Depends on acp_pkg, the channel interfaces, acp_checker and arc_page_replacer_top.
module testbench;
	localparam int IDLE_LIMIT = 4000;

	logic                       clk = 0;
	logic                       arst_n = 0;
	logic                       cfg_we = 0;
	logic [acp_pkg::CAP_W-1:0]  cfg_wdata = 0;
	int                         errors, outstanding, idle_cycles = 0;
	bit                         calm = 0, hold_go = 0;
	int                         cap_now = 16;
	logic [acp_pkg::PAGE_W-1:0] last_page[acp_pkg::FRAME_SLOTS];
	logic [acp_pkg::PAGE_W-1:0] page_pool[24];

	acp_req_if req();
	acp_rsp_if rsp();

	arc_page_replacer_top dut (.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata), .req(req), .rsp(rsp));

	acp_checker chk (.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req(req), .rsp(rsp), .errors(errors), .outstanding(outstanding));

	always #1 clk = ~clk;

	initial begin
		req.valid = 0;
		req.command = acp_pkg::CMD_ACCESS;
		req.frame_sel = 0;
		req.page_id = 0;
		req.make_evictable = 0;
		rsp.ready = 0;
	end

	// receiver side: random stall bursts, one long hold-off on request
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_go) begin
				rsp.ready = 0;
				repeat (300) @(negedge clk);
				hold_go = 0;
				rsp.ready = 1;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				rsp.ready = 0;
				n = $urandom_range(1, 3);
				repeat (n - 1) @(negedge clk);
			end else rsp.ready = 1;
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
		else if (arst_n) idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	task automatic send(acp_pkg::cmd_t cmd, int f, logic [acp_pkg::PAGE_W-1:0] p, bit mk);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			req.valid = 0;
			gap = $urandom_range(1, 3);
			repeat (gap) @(negedge clk);
		end
		req.valid = 1;
		req.command = cmd;
		req.frame_sel = acp_pkg::FRAME_W'(f);
		req.page_id = p;
		req.make_evictable = mk;
		if (cmd == acp_pkg::CMD_ACCESS) last_page[f] = p;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		req.valid = 0;
		while (outstanding != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic set_capacity(logic [acp_pkg::CAP_W-1:0] v);
		drain();
		cfg_we = 1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 0;
		cap_now = (v < 1) ? 1 : (v > 16) ? 16 : v;
	endtask

	task automatic random_item();
		int k, f;
		logic [acp_pkg::PAGE_W-1:0] p;
		k = $urandom_range(0, 99);
		f = (k % 17 == 0) ? $urandom_range(0, 15) : $urandom_range(0, cap_now - 1);
		if ($urandom_range(0, 1)) p = last_page[f];
		else if ($urandom_range(0, 9) == 0) p = acp_pkg::PAGE_W'($urandom);
		else p = page_pool[$urandom_range(0, 23)];
		if (k < 40) send(acp_pkg::CMD_ACCESS, f, p, $urandom_range(0, 1));
		else if (k < 65) send(acp_pkg::CMD_SET_EVICT, f, p, $urandom_range(0, 3) != 0);
		else if (k < 75) send(acp_pkg::CMD_REMOVE, f, p, $urandom_range(0, 1));
		else send(acp_pkg::CMD_EVICT, f, p, $urandom_range(0, 1));
	endtask

	initial begin
		logic [acp_pkg::CAP_W-1:0] caps[6] = '{16, 4, 1, 31, 0, 9};
		foreach (page_pool[i]) page_pool[i] = acp_pkg::PAGE_W'($urandom);
		page_pool[0] = '0;
		page_pool[1] = '1;
		foreach (last_page[i]) last_page[i] = page_pool[i];
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		send(acp_pkg::CMD_ACCESS, 0, '0, 0);
		send(acp_pkg::CMD_ACCESS, 15, '1, 1);
		send(acp_pkg::CMD_ACCESS, 0, 5, 0);
		send(acp_pkg::CMD_ACCESS, 0, '0, 0);
		send(acp_pkg::CMD_SET_EVICT, 0, 0, 1);
		send(acp_pkg::CMD_SET_EVICT, 15, 0, 1);
		send(acp_pkg::CMD_SET_EVICT, 15, 0, 0);
		send(acp_pkg::CMD_REMOVE, 15, 0, 0);
		send(acp_pkg::CMD_REMOVE, 7, 0, 0);
		send(acp_pkg::CMD_SET_EVICT, 7, 0, 1);
		send(acp_pkg::CMD_EVICT, 0, 0, 0);
		send(acp_pkg::CMD_EVICT, 0, 0, 0);
		send(acp_pkg::CMD_ACCESS, 3, '0, 0);
		send(acp_pkg::CMD_SET_EVICT, 15, 0, 1);
		send(acp_pkg::CMD_EVICT, 0, 0, 0);
		send(acp_pkg::CMD_ACCESS, 4, '1, 0);
		send(acp_pkg::CMD_SET_EVICT, 3, 0, 1);
		send(acp_pkg::CMD_REMOVE, 3, 0, 1);
		set_capacity(1);
		send(acp_pkg::CMD_ACCESS, 1, 3, 0);
		send(acp_pkg::CMD_SET_EVICT, 1, 0, 1);
		send(acp_pkg::CMD_ACCESS, 0, 9, 0);
		send(acp_pkg::CMD_REMOVE, 12, 0, 0);
		send(acp_pkg::CMD_EVICT, 0, 0, 0);

		foreach (caps[i]) begin
			set_capacity(caps[i]);
			if (i == 1) begin
				hold_go = 1;
				repeat (20) random_item();
			end
			repeat (150) random_item();
		end
		set_capacity(16);
		calm = 1;
		repeat (100) random_item();

		drain();
		if (errors == 0) $display("testbench: clean");
		else $display("testbench: errors");
		$finish;
	end
endmodule

// ===== arc_page_replacer_top.f =====
+incdir+rtl/core
rtl/core/acp_pkg.sv
rtl/core/acp_ifs.sv
rtl/core/acp_order_cell.sv
rtl/core/acp_ghost_cell.sv
rtl/core/arc_page_replacer_top.sv
bench/acp_checker.sv
bench/testbench.sv
